@@ hw/rtl/filtered_k_nearest_select_top_assert.svh @@
// Assertion macros for the filtered k-nearest select block.
`ifndef FILTERED_K_NEAREST_SELECT_TOP_ASSERT_SVH
`define FILTERED_K_NEAREST_SELECT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FKN_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("label failed");
`define FKN_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("label failed");
`else
`define FKN_ASSERT_IMP(label, clk, rst, a, b)
`define FKN_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

@@ hw/rtl/fkn_pkg.sv @@
// Package: constants, types and control structs of the k-nearest select block.
package fkn_pkg;
  localparam int ENTRIES_DEF = 64;
  localparam int MAX_PICK_DEF = 8;
  localparam int TYPES_DEF = 8;
  localparam int COORD_BITS_DEF = 20;
  localparam int SLOT_W = 6;
  localparam int MASK_W = 8;
  localparam int COORD_W = 20;
  localparam int WANT_W = 4;
  localparam int KIND_W = 3;
  localparam int DIST_W = 42;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_SCAN, ST_DRAIN, ST_EMIT, ST_EMPTY
  } fkn_state_t;

  typedef struct packed {
    logic load_query;
    logic scan_start;
    logic scan_step;
    logic emit_start;
    logic emit_step;
  } fkn_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic drain_done;
    logic any;
    logic emit_last;
  } fkn_stat_t;
endpackage

@@ hw/rtl/fkn_ram.sv @@
// Generic single-port write, single-port registered-read RAM.
module fkn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/fkn_ctrl.sv @@
// Controller state machine: sequences write, scan, drain and emit.
module fkn_ctrl import fkn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output fkn_cmd_t  cmd,
  input  fkn_stat_t stat,
  output logic      out_empty
);
  fkn_state_t state, state_next;
  logic acc, give;
  assign acc = in_valid && !in_stall;
  assign give = out_valid && !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (acc && in_op == OP_QUERY) state_next = ST_RD;
      ST_RD:    state_next = ST_SCAN;
      ST_SCAN:  if (stat.scan_done) state_next = ST_DRAIN;
      ST_DRAIN: if (stat.drain_done) state_next = stat.any ? ST_EMIT : ST_EMPTY;
      ST_EMIT:  if (give && stat.emit_last) state_next = ST_IDLE;
      ST_EMPTY: if (give) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != ST_IDLE);
    out_valid = (state == ST_EMIT) || (state == ST_EMPTY);
    out_empty = (state == ST_EMPTY);
    cmd.load_query = (state == ST_IDLE) && acc && in_op == OP_QUERY;
    cmd.scan_start = (state == ST_RD);
    cmd.scan_step = (state == ST_SCAN);
    cmd.emit_start = (state == ST_DRAIN) && stat.drain_done;
    cmd.emit_step = (state == ST_EMIT) && give;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `include "filtered_k_nearest_select_top_assert.svh"
  `FKN_ASSERT_IMP(a_no_out_idle, clk, rst, state == ST_IDLE, !out_valid)
  `FKN_ASSERT_NXT(a_query_reads, clk, rst, cmd.load_query, state == ST_RD)
  `FKN_ASSERT_IMP(a_empty_last, clk, rst, out_empty, out_valid)
endmodule

@@ hw/rtl/fkn_dpath.sv @@
// Datapath: entry table, distance pipeline and sorted pick list.
module fkn_dpath import fkn_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int MAX_PICK = MAX_PICK_DEF,
  parameter int TYPES = TYPES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [7:0]          owner_id,
  input  logic                is_active,
  input  logic [MASK_W-1:0]   supports_mask,
  input  logic [MASK_W-1:0]   full_mask,
  input  logic [COORD_W-1:0]  pos_x,
  input  logic [COORD_W-1:0]  pos_y,
  input  logic [COORD_W-1:0]  pos_z,
  input  logic [WANT_W-1:0]   want_count,
  input  logic [KIND_W-1:0]   kind,
  input  fkn_cmd_t            cmd,
  output fkn_stat_t           stat,
  output logic [SLOT_W-1:0]   match_slot,
  output logic [DIST_W-1:0]   dist_sq
);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
  localparam int KW = $clog2(MAX_PICK + 1);
  localparam int AT_W = 8 + 1 + 2 * TYPES;
  localparam int PS_W = COORD_BITS * 3;
  localparam int DFW = COORD_BITS + 1;

  logic [AT_W-1:0] at_w, at_r;
  logic [PS_W-1:0] ps_w, ps_r;
  logic [ENTRIES-1:0] valid;
  logic [AW:0] ridx;
  logic [AW-1:0] raddr;
  logic wr_ok;
  logic [TYPES-1:0] sup_in, full_in;

  assign sup_in = TYPES'(supports_mask);
  assign full_in = TYPES'(full_mask);
  assign wr_ok = wr_en && ({{(AW+1){1'b0}}, slot} < (AW+1+SLOT_W)'(ENTRIES));
  assign at_w = {owner_id, is_active, sup_in, full_in};
  assign ps_w = {pos_x[COORD_BITS-1:0], pos_y[COORD_BITS-1:0], pos_z[COORD_BITS-1:0]};
  assign raddr = ridx[AW-1:0];

  fkn_ram #(.WIDTH(AT_W), .DEPTH(ENTRIES)) u_attr (
    .clk(clk), .we(wr_ok), .waddr(slot[AW-1:0]), .wdata(at_w),
    .raddr(raddr), .rdata(at_r));
  fkn_ram #(.WIDTH(PS_W), .DEPTH(ENTRIES)) u_pos (
    .clk(clk), .we(wr_ok), .waddr(slot[AW-1:0]), .wdata(ps_w),
    .raddr(raddr), .rdata(ps_r));

  // query registers
  logic [7:0] q_owner;
  logic [COORD_BITS-1:0] qx, qy, qz;
  logic [KW-1:0] k;
  logic kind_ok;
  logic [TYPES-1:0] kbit;

  // stage 1: fetched entry
  logic s1_v;
  logic [AW-1:0] s1_idx, s2_idx, s3_idx;
  logic s2_v, s3_v;
  logic [DFW-1:0] dx, dy, dz;
  logic [2*DFW-1:0] sx, sy, sz;
  logic [DIST_W-1:0] d3;

  logic [AW-1:0] rd_idx;
  logic rd_v;

  logic [7:0] e_owner;
  logic e_act;
  logic [TYPES-1:0] e_sup, e_full;
  logic e_ok;
  assign {e_owner, e_act, e_sup, e_full} = at_r;
  assign e_ok = valid[rd_idx] && e_owner == q_owner && e_act && kind_ok &&
                |(e_sup & kbit) && !(|(e_full & kbit));

  function automatic logic [DFW-1:0] adiff(input logic [COORD_BITS-1:0] a,
                                           input logic [COORD_BITS-1:0] b);
    logic signed [DFW-1:0] d;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    return d[DFW-1] ? DFW'(-d) : DFW'(d);
  endfunction

  logic [DIST_W+1:0] sum;
  assign sum = (DIST_W+2)'(sx) + (DIST_W+2)'(sy) + (DIST_W+2)'(sz);

  // pick list
  logic [AW-1:0] b_slot [MAX_PICK];
  logic [DIST_W-1:0] b_dist [MAX_PICK];
  logic [KW-1:0] n, ei;
  logic ins;
  logic [MAX_PICK-1:0] gt;

  always_comb begin
    for (int p = 0; p < MAX_PICK; p++) begin
      gt[p] = (KW'(p) < n) && (b_dist[p] > d3);
    end
    ins = s3_v && (k != '0) && ((n < k) || gt[PW'(k - 1'b1)]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_ok) begin
      valid[slot[AW-1:0]] <= 1'b1;
    end
    if (cmd.load_query) begin
      q_owner <= owner_id;
      qx <= pos_x[COORD_BITS-1:0];
      qy <= pos_y[COORD_BITS-1:0];
      qz <= pos_z[COORD_BITS-1:0];
      k <= ({{(KW > WANT_W ? KW - WANT_W : 0){1'b0}}, want_count} > (KW+WANT_W)'(MAX_PICK))
           ? KW'(MAX_PICK) : KW'(want_count);
      kind_ok <= (32'(kind) < TYPES);
      kbit <= TYPES'(1) << kind;
      ridx <= '0;
    end
    rd_v <= 1'b0;
    s1_v <= 1'b0;
    if (cmd.scan_start || (cmd.scan_step && !stat.scan_done)) begin
      rd_v <= 1'b1;
      rd_idx <= raddr;
      ridx <= ridx + 1'b1;
    end
    if (rd_v) begin
      s1_v <= e_ok;
      s1_idx <= rd_idx;
      dx <= adiff(qx, ps_r[3*COORD_BITS-1:2*COORD_BITS]);
      dy <= adiff(qy, ps_r[2*COORD_BITS-1:COORD_BITS]);
      dz <= adiff(qz, ps_r[COORD_BITS-1:0]);
    end
    s2_v <= s1_v;
    s2_idx <= s1_idx;
    sx <= dx * dx;
    sy <= dy * dy;
    sz <= dz * dz;
    s3_v <= s2_v;
    s3_idx <= s2_idx;
    d3 <= (sum > (DIST_W+2)'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
    if (rst || cmd.load_query) begin
      n <= '0;
    end else if (ins) begin
      for (int p = 0; p < MAX_PICK; p++) begin
        if (KW'(p) < k && (KW'(p) == n || gt[p])) begin
          if (p == 0 || !gt[(p > 0) ? p - 1 : 0]) begin
            b_slot[p] <= s3_idx;
            b_dist[p] <= d3;
          end else begin
            b_slot[p] <= b_slot[(p > 0) ? p - 1 : 0];
            b_dist[p] <= b_dist[(p > 0) ? p - 1 : 0];
          end
        end
      end
      if (n < k) n <= n + 1'b1;
    end
    if (cmd.emit_start) begin
      ei <= '0;
    end else if (cmd.emit_step) begin
      ei <= ei + 1'b1;
    end
  end

  assign stat.scan_done = (ridx == (AW+1)'(ENTRIES)) || (k == '0) || !kind_ok;
  assign stat.drain_done = !rd_v && !s1_v && !s2_v && !s3_v;
  assign stat.any = (n != '0);
  assign stat.emit_last = (ei + 1'b1 == n);
  assign match_slot = SLOT_W'(b_slot[ei[PW-1:0]]);
  assign dist_sq = b_dist[ei[PW-1:0]];

  `include "filtered_k_nearest_select_top_assert.svh"
  `FKN_ASSERT_IMP(a_n_le_k, clk, rst, 1'b1, n <= k || cmd.load_query || n == '0 || k != '0)
  `FKN_ASSERT_IMP(a_ins_room, clk, rst, ins, k != '0)
  `FKN_ASSERT_NXT(a_emit_start, clk, rst, cmd.emit_start, ei == '0)
endmodule

@@ hw/rtl/filtered_k_nearest_select_top.sv @@
// Top level of the filtered k-nearest select block.
// A write word stores one table entry. A query scans all ENTRIES entries (none
// if want_count is 0 or kind >= TYPES) through a registered-read table and a
// three-stage distance pipeline, one entry a cycle, inserting matches into a
// sorted list of MAX_PICK, then emits one result word a cycle unless stalled.
module filtered_k_nearest_select_top import fkn_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int MAX_PICK = MAX_PICK_DEF,
  parameter int TYPES = TYPES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [7:0]         owner_id,
  input  logic               is_active,
  input  logic [MASK_W-1:0]  supports_mask,
  input  logic [MASK_W-1:0]  full_mask,
  input  logic [COORD_W-1:0] pos_x,
  input  logic [COORD_W-1:0] pos_y,
  input  logic [COORD_W-1:0] pos_z,
  input  logic [WANT_W-1:0]  want_count,
  input  logic [KIND_W-1:0]  kind,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               has_result,
  output logic [SLOT_W-1:0]  match_slot,
  output logic [DIST_W-1:0]  dist_sq,
  output logic               last
);
  fkn_cmd_t cmd;
  fkn_stat_t stat;
  logic empty;
  logic [SLOT_W-1:0] m_slot;
  logic [DIST_W-1:0] m_dist;

  fkn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_op(op), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat),
    .out_empty(empty));

  fkn_dpath #(.ENTRIES(ENTRIES), .MAX_PICK(MAX_PICK), .TYPES(TYPES),
              .COORD_BITS(COORD_BITS)) u_dpath (
    .clk(clk), .rst(rst), .wr_en(in_valid && !in_stall && op == OP_WRITE),
    .slot(slot), .owner_id(owner_id), .is_active(is_active),
    .supports_mask(supports_mask), .full_mask(full_mask),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .want_count(want_count),
    .kind(kind), .cmd(cmd), .stat(stat), .match_slot(m_slot), .dist_sq(m_dist));

  assign has_result = !empty;
  assign match_slot = empty ? '0 : m_slot;
  assign dist_sq = empty ? '0 : m_dist;
  assign last = empty || stat.emit_last;
endmodule
